>>> rtl/core/efr_pkg.sv
package efr_pkg;

  // Framing characters on the serial line.
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SOH = 8'h01;

  // Result word kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CSUM  = 2'd2;

  localparam logic [5:0]  PLEN_SAT  = 6'd63;
  localparam logic [15:0] TALLY_MAX = 16'hffff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JUDGE,
    S_SUM,
    S_CHK,
    S_CMP,
    S_DRD,
    S_DOUT,
    S_VERDICT
  } efr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       rd_chk;
    logic       sum_init;
    logic       sum_rd;
    logic       idx_ld;
    logic       idx_ld_data;
    logic       idx_inc;
    logic       bump;
    logic       load_pay;
    logic       load_verdict;
    logic       clear_fill;
    logic [1:0] vcode;
  } efr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic etx;
    logic is_short;
    logic sum_last;
    logic csum_bad;
    logic pay_empty;
    logic out_free;
  } efr_stat_t;

endpackage

>>> rtl/core/efr_if.sv
interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  port;
  logic [7:0]  seq_id;
  logic [7:0]  opcode;
  logic [5:0]  payload_length;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [15:0] errors_seen;
  logic        last;

  modport source (
    output valid, output kind, output port, output seq_id, output opcode,
    output payload_length, output data_byte, output status,
    output errors_seen, output last, input ready
  );
  modport sink (
    input valid, input kind, input port, input seq_id, input opcode,
    input payload_length, input data_byte, input status,
    input errors_seen, input last, output ready
  );
endinterface

>>> rtl/core/efr_datapath.sv
module efr_datapath import efr_pkg::*; #(
  parameter int FRAME_MAX = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  efr_cmd_t       cmd,
  output efr_stat_t      stat,
  input  logic [7:0]     rx_byte,
  efr_result_if.source   out_ch
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = $clog2(FRAME_MAX + 1);

  logic [7:0]    mem [FRAME_MAX];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          skip_r, skip_nxt;
  logic [7:0]    last_r;
  logic [7:0]    port_r, id_r, op_r, plen_r;
  logic [15:0]   tally_r;
  logic [7:0]    xor_r;
  logic          acc_v_r;
  logic [AW-1:0] idx_r;

  logic          o_valid_r;
  logic          o_kind_r;
  logic [7:0]    o_port_r, o_id_r, o_op_r, o_data_r;
  logic [5:0]    o_plen_r;
  logic [1:0]    o_status_r;
  logic [15:0]   o_err_r;
  logic          o_last_r;

  logic [CW-1:0] n1;
  logic          slip;
  logic          etx;
  logic [7:0]    dlen;
  logic [7:0]    hdr_id, hdr_op;
  logic [AW-1:0] end_idx;
  logic [CW-1:0] chk_full;
  logic [AW-1:0] rd_addr;
  logic          out_free;
  logic          do_bump;

  // Byte-level framing: header check, escape pairs, trailer, overflow.
  always_comb begin
    n1       = fill_r + CW'(1);
    fill_nxt = n1;
    skip_nxt = skip_r;
    slip     = 1'b0;
    etx      = 1'b0;
    if (n1 == CW'(2)) begin
      if (last_r != CH_ESC || rx_byte != CH_STX) begin
        fill_nxt = CW'(1);
        slip     = 1'b1;
      end
    end else if (n1 > CW'(2)) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (last_r == CH_ESC && rx_byte == CH_NUL) begin
        skip_nxt = 1'b1;
        fill_nxt = n1 - CW'(1);
      end else if (last_r == CH_ESC && rx_byte == CH_SOH) begin
        skip_nxt = 1'b1;
        fill_nxt = n1 - CW'(2);
      end else if (last_r == CH_ESC && rx_byte == CH_ETX) begin
        etx = 1'b1;
      end
      if (!etx && fill_nxt == CW'(FRAME_MAX)) begin
        fill_nxt = '0;
      end
    end
  end

  // Header fields count only when the frame really reached them.
  assign hdr_id   = (fill_r > CW'(3)) ? id_r : 8'd0;
  assign hdr_op   = (fill_r > CW'(4)) ? op_r : 8'd0;
  assign dlen     = (fill_r > CW'(5)) ? plen_r : 8'd0;
  assign end_idx  = dlen[AW-1:0] + AW'(5);
  assign chk_full = fill_r - CW'(3);
  assign rd_addr  = cmd.rd_chk ? chk_full[AW-1:0] : idx_r;
  assign out_free = !o_valid_r || out_ch.ready;
  assign do_bump  = (cmd.accept && slip) || cmd.bump;

  assign stat.etx       = etx;
  assign stat.is_short  = ({1'b0, dlen} + 9'd8) > 9'(fill_r);
  assign stat.sum_last  = (idx_r == end_idx);
  assign stat.csum_bad  = (xor_r != rd_data_r);
  assign stat.pay_empty = (dlen == 8'd0);
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[fill_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      skip_r  <= 1'b0;
      tally_r <= '0;
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.sum_rd;
      if (cmd.accept) begin
        fill_r <= fill_nxt;
        skip_r <= skip_nxt;
      end else if (cmd.clear_fill) begin
        fill_r <= '0;
      end
      if (do_bump && tally_r != TALLY_MAX) begin
        tally_r <= tally_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r <= rx_byte;
      if (fill_r == CW'(2)) port_r <= rx_byte;
      if (fill_r == CW'(3)) id_r   <= rx_byte;
      if (fill_r == CW'(4)) op_r   <= rx_byte;
      if (fill_r == CW'(5)) plen_r <= rx_byte;
    end
    if (cmd.sum_init) begin
      xor_r <= 8'd0;
    end else if (acc_v_r) begin
      xor_r <= xor_r ^ rd_data_r;
    end
    if (cmd.idx_ld) begin
      idx_r <= cmd.idx_ld_data ? AW'(6) : AW'(2);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (cmd.load_pay || cmd.load_verdict) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pay || cmd.load_verdict) begin
      o_kind_r   <= cmd.load_verdict ? KIND_VERDICT : KIND_DATA;
      o_port_r   <= port_r;
      o_id_r     <= hdr_id;
      o_op_r     <= hdr_op;
      o_plen_r   <= (dlen > 8'(PLEN_SAT)) ? PLEN_SAT : dlen[5:0];
      o_data_r   <= cmd.load_verdict ? 8'd0 : rd_data_r;
      o_status_r <= cmd.load_verdict ? cmd.vcode : ST_OK;
      o_err_r    <= tally_r;
      o_last_r   <= cmd.load_verdict;
    end
  end

  assign out_ch.valid          = o_valid_r;
  assign out_ch.kind           = o_kind_r;
  assign out_ch.port           = o_port_r;
  assign out_ch.seq_id         = o_id_r;
  assign out_ch.opcode         = o_op_r;
  assign out_ch.payload_length = o_plen_r;
  assign out_ch.data_byte      = o_data_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.errors_seen    = o_err_r;
  assign out_ch.last           = o_last_r;

endmodule

>>> rtl/core/efr_ctrl.sv
module efr_ctrl import efr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  efr_stat_t stat,
  output efr_cmd_t  cmd
);

  efr_state_t state_r, state_nxt;
  logic [1:0] vcode_r, vcode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcode_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      vcode_r <= vcode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    vcode_nxt = vcode_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && stat.etx) state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        if (stat.is_short) begin
          state_nxt = S_VERDICT;
          vcode_nxt = ST_SHORT;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (stat.sum_last) state_nxt = S_CHK;
      end
      S_CHK: state_nxt = S_CMP;
      S_CMP: begin
        if (stat.csum_bad) begin
          state_nxt = S_VERDICT;
          vcode_nxt = ST_CSUM;
        end else if (stat.pay_empty) begin
          state_nxt = S_VERDICT;
          vcode_nxt = ST_OK;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_DRD: state_nxt = S_DOUT;
      S_DOUT: begin
        if (stat.out_free) begin
          if (stat.sum_last) begin
            state_nxt = S_VERDICT;
            vcode_nxt = ST_OK;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      S_VERDICT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.vcode = vcode_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_JUDGE: begin
        if (!stat.is_short) begin
          cmd.idx_ld   = 1'b1;
          cmd.sum_init = 1'b1;
        end
      end
      S_SUM: begin
        cmd.rd_en   = 1'b1;
        cmd.sum_rd  = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_CHK: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_chk = 1'b1;
      end
      S_CMP: begin
        if (stat.csum_bad) begin
          cmd.bump = 1'b1;
        end else begin
          cmd.idx_ld      = 1'b1;
          cmd.idx_ld_data = 1'b1;
        end
      end
      S_DRD: cmd.rd_en = 1'b1;
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.load_pay = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_VERDICT: begin
        if (stat.out_free) begin
          cmd.load_verdict = 1'b1;
          cmd.clear_fill   = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/escaped_frame_receiver_top.sv
// Throughput: one received byte per cycle while no trailer is seen.
// Sequence: a trailer whose frame is too short moves from the judge state to
// the verdict state, which loads the verdict word once the output register is
// free. A frame with L payload bytes keeps the block busy, set by the single
// read port of the frame store: checksum sweep, then a read and an output state per payload byte.
// Reset: rst_n is synchronous and active low; the frame store is not cleared.
module escaped_frame_receiver_top import efr_pkg::*; #(
  parameter int FRAME_MAX = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  efr_byte_if.sink      in_ch,
  efr_result_if.source  out_ch
);

  // The controller sequences each trailer: a short-frame test, a sweep of the
  // store that XORs port through payload, a read of the checksum byte, then
  // the payload words and the verdict. The datapath owns the frame store, the
  // escape handling done as each word arrives, the error count and the
  // output register that lets a new word in while a verdict still waits.
  efr_cmd_t  cmd;
  efr_stat_t stat;

  efr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  efr_datapath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .rx_byte (in_ch.rx_byte),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/core/efr_checker.sv
module efr_checker import efr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_data_byte,
  input logic [1:0]  out_status,
  input logic [15:0] out_errors_seen,
  input logic        out_last
);

  // A pending word stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  // A stalled word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_data_byte) &&
      $stable(out_status) && $stable(out_errors_seen) && $stable(out_last))
    else $error("stalled output word changed");

  // While payload is pending the verdict is still to come, so no byte is taken.
  a_busy_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> !in_ready)
    else $error("input taken during payload drain");

  // Taking a byte never produces a result in the very next cycle.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a byte was taken");

  // Payload words are never the closing word and carry no status.
  a_pay_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> !out_last && out_status == ST_OK)
    else $error("payload word marked as verdict");

endmodule

bind escaped_frame_receiver_top efr_checker u_efr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_data_byte   (out_ch.data_byte),
  .out_status      (out_ch.status),
  .out_errors_seen (out_ch.errors_seen),
  .out_last        (out_ch.last)
);
